// ----- rtl/aps_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants of the box pair collision sweep
// Holds the request and result payloads, the stored object record and the
// record that travels from the front end to the sweep engine.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int MaxObjectsDef = 8;
    localparam int IndexW        = 3;

    localparam logic [7:0] HitMask     = 8'h02;
    localparam logic [7:0] ContactMask = 8'hC1;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [30:0]        extent_x;
        logic [30:0]        extent_y;
        logic [30:0]        extent_z;
        logic [7:0]         send_mask;
        logic [7:0]         recv_mask;
        logic               last_object;
    } in_item_t;

    typedef struct packed {
        logic [IndexW-1:0] source_index;
        logic [IndexW-1:0] target_index;
        logic              fire_hit;
        logic              fire_contact;
        logic              last_result;
    } out_item_t;

    typedef struct packed {
        logic [31:0] corner_x;
        logic [31:0] corner_y;
        logic [31:0] corner_z;
        logic [30:0] size_x;
        logic [30:0] size_y;
        logic [30:0] size_z;
        logic [7:0]  send;
        logic [7:0]  recv;
    } obj_t;

    typedef struct packed {
        obj_t              obj;
        logic              store;
        logic              last;
        logic [IndexW-1:0] index;
        logic [IndexW-1:0] last_idx;
    } rec_t;

endpackage
`default_nettype wire

// ----- rtl/aps_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aps_front: request intake
// Forms the box corners, tracks the load count and tags each request as
// stored, dropped or sweep start before it enters the record queue.
// ----------------------------------------------------------------------------
module aps_front #(
    parameter int MAX_OBJECTS = aps_pkg::MaxObjectsDef
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  aps_pkg::in_item_t s_data,
    output logic             q_valid,
    input  wire              q_ready,
    output aps_pkg::rec_t    q_data
);
    import aps_pkg::*;

    localparam int CntW = $clog2(MAX_OBJECTS + 1);

    logic [CntW-1:0] count_reg, count_next;
    logic            accept;
    logic            store;

    assign s_ready = q_ready;
    assign accept  = s_valid && s_ready;
    assign store   = count_reg < CntW'(MAX_OBJECTS);

    // A request that arrives on a full table is dropped, unless it starts the sweep.
    assign q_valid = s_valid && (store || s_data.last_object);

    always_comb begin
        q_data.obj.corner_x = $unsigned(s_data.pos_x + s_data.offset_x);
        q_data.obj.corner_y = $unsigned(s_data.pos_y + s_data.offset_y);
        q_data.obj.corner_z = $unsigned(s_data.pos_z + s_data.offset_z);
        q_data.obj.size_x   = s_data.extent_x;
        q_data.obj.size_y   = s_data.extent_y;
        q_data.obj.size_z   = s_data.extent_z;
        q_data.obj.send     = s_data.send_mask;
        q_data.obj.recv     = s_data.recv_mask;
        q_data.store        = store;
        q_data.last         = s_data.last_object;
        q_data.index        = IndexW'(count_reg);
        q_data.last_idx     = store ? IndexW'(count_reg) : IndexW'(MAX_OBJECTS - 1);
    end

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (s_data.last_object) begin
                count_next = '0;
            end else if (store) begin
                count_next = count_reg + CntW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CntW'(MAX_OBJECTS))
        else $error("load count ran past the table depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.last_object |=> count_reg == '0)
        else $error("load count not cleared after the sweep start");

    assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && q_data.store |-> q_data.index == q_data.last_idx || !q_data.last)
        else $error("stored sweep start does not close the object list");
`endif

endmodule
`default_nettype wire

// ----- rtl/aps_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aps_queue: two-entry record queue
// Lets the intake keep taking requests while the sweep engine is busy.
// ----------------------------------------------------------------------------
module aps_queue (
    input  wire           aclk,
    input  wire           aresetn,
    input  wire           in_valid,
    output logic          in_ready,
    input  aps_pkg::rec_t in_data,
    output logic          out_valid,
    input  wire           out_ready,
    output aps_pkg::rec_t out_data
);
    import aps_pkg::*;

    localparam int Depth = 2;
    localparam int PtrW  = $clog2(Depth);
    localparam int FillW = $clog2(Depth + 1);

    rec_t             entry_reg [Depth];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FillW-1:0] fill_reg, fill_next;
    logic             push;
    logic             pop;

    assign in_ready  = fill_reg != FillW'(Depth);
    assign out_valid = fill_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + FillW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - FillW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FillW'(Depth))
        else $error("record queue overfilled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == '0 || fill_reg == FillW'(Depth)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with fill level");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> fill_reg == $past(fill_reg) + FillW'(1))
        else $error("queue fill level missed a write");
`endif

endmodule
`default_nettype wire

// ----- rtl/aps_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aps_back: object table and pair sweep engine
// Writes stored records into the object table and, on a sweep start, tests
// one ordered source and target pair per cycle while the output does not
// stall, holding each hit until the next so the last result can be flagged.
// ----------------------------------------------------------------------------
module aps_back #(
    parameter int MAX_OBJECTS = aps_pkg::MaxObjectsDef
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               q_valid,
    output logic              q_ready,
    input  aps_pkg::rec_t     q_data,
    output logic              m_valid,
    input  wire               m_ready,
    output aps_pkg::out_item_t m_data
);
    import aps_pkg::*;

    localparam int IdxW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    function automatic logic axis_overlap(input logic [31:0] a, input logic [30:0] a_size,
                                          input logic [31:0] b, input logic [30:0] b_size);
        logic signed [32:0] sa;
        logic signed [32:0] sb;
        logic signed [32:0] ea;
        logic signed [32:0] eb;
        sa = $signed({a[31], a});
        sb = $signed({b[31], b});
        ea = sa + $signed({2'b00, a_size});
        eb = sb + $signed({2'b00, b_size});
        return (sb <= ea) && (sa <= eb);
    endfunction

    obj_t            table_mem [MAX_OBJECTS];
    obj_t            src_obj_reg;
    obj_t            tgt_obj_reg;
    logic [IdxW-1:0] rd_src_reg;
    logic [IdxW-1:0] rd_tgt_reg;

    state_t          state_reg, state_next;
    logic [IdxW-1:0] src_reg, src_next;
    logic [IdxW-1:0] tgt_reg, tgt_next;
    logic [IdxW-1:0] last_reg, last_next;
    logic            rd_valid_reg, rd_valid_next;
    logic            pend_valid_reg, pend_valid_next;
    out_item_t       pend_reg, pend_next;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_data_reg, m_data_next;

    logic            adv;
    logic            pop;
    logic            issue;
    logic            hit;
    out_item_t       found;

    // The whole sweep pipeline holds while a result waits at the output.
    assign adv     = !m_valid_reg || m_ready;
    assign q_ready = state_reg == ST_IDLE;
    assign pop     = q_valid && q_ready;
    assign issue   = (state_reg == ST_SWEEP) && adv;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign hit = rd_valid_reg
              && (|(src_obj_reg.send & tgt_obj_reg.recv))
              && axis_overlap(src_obj_reg.corner_x, src_obj_reg.size_x,
                              tgt_obj_reg.corner_x, tgt_obj_reg.size_x)
              && axis_overlap(src_obj_reg.corner_y, src_obj_reg.size_y,
                              tgt_obj_reg.corner_y, tgt_obj_reg.size_y)
              && axis_overlap(src_obj_reg.corner_z, src_obj_reg.size_z,
                              tgt_obj_reg.corner_z, tgt_obj_reg.size_z);

    always_comb begin
        found.source_index = IndexW'(rd_src_reg);
        found.target_index = IndexW'(rd_tgt_reg);
        found.fire_hit     = |(src_obj_reg.send & HitMask);
        found.fire_contact = |(src_obj_reg.send & ContactMask);
        found.last_result  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (pop && q_data.store) begin
            table_mem[q_data.index[IdxW-1:0]] <= q_data.obj;
        end
        if (issue) begin
            src_obj_reg <= table_mem[src_reg];
            tgt_obj_reg <= table_mem[tgt_reg];
            rd_src_reg  <= src_reg;
            rd_tgt_reg  <= tgt_reg;
        end
    end

    always_comb begin
        state_next      = state_reg;
        src_next        = src_reg;
        tgt_next        = tgt_reg;
        last_next       = last_reg;
        rd_valid_next   = rd_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (adv) begin
            rd_valid_next = issue;
        end

        case (state_reg)
            ST_IDLE: begin
                if (pop && q_data.last) begin
                    src_next   = '0;
                    tgt_next   = '0;
                    last_next  = q_data.last_idx[IdxW-1:0];
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (adv) begin
                    if (tgt_reg == last_reg) begin
                        tgt_next = '0;
                        if (src_reg == last_reg) begin
                            state_next = ST_DRAIN;
                        end else begin
                            src_next = src_reg + IdxW'(1);
                        end
                    end else begin
                        tgt_next = tgt_reg + IdxW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (adv) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // A sweep without hits still closes with one empty result.
                if (adv) begin
                    m_valid_next = 1'b1;
                    m_data_next  = pend_valid_reg ? pend_reg : '0;
                    m_data_next.last_result = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (adv && hit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_data_next  = pend_reg;
            end
            pend_next       = found;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            src_reg        <= '0;
            tgt_reg        <= '0;
            last_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            src_reg        <= src_next;
            tgt_reg        <= tgt_next;
            last_reg       <= last_next;
            rd_valid_reg   <= rd_valid_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        pend_reg   <= pend_next;
        m_data_reg <= m_data_next;
    end

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> !pend_valid_reg)
        else $error("held hit left over after the sweep closed");

    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> (state_reg == ST_SWEEP || state_reg == ST_DRAIN))
        else $error("table read in flight outside the sweep");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SWEEP |-> src_reg <= last_reg && tgt_reg <= last_reg)
        else $error("sweep index beyond the loaded objects");

    // The idle state may still take in records while the final result waits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready && pend_valid_reg |=> $stable(pend_reg) && $stable(state_reg))
        else $error("sweep moved on while a result was stalled");
`endif

endmodule
`default_nettype wire

// ----- rtl/aabb_pair_collision_sweep.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// aabb_pair_collision_sweep: all-pairs box collision sweep
// Loads object records, then reports every colliding source and target pair.
// ----------------------------------------------------------------------------
// Each request carries one object; non-final requests are taken at one per
// cycle through a two-entry record queue and stored in the object table. The
// request marked last_object starts a sweep that tests every ordered pair of
// the loaded objects, one pair per cycle on the table's two read ports;
// requests queue up meanwhile and the input stalls once the queue is full.
// Results come out in source-major order, the final one flagged with
// last_result; a sweep without hits gives one empty flagged result. A
// stall on the result side holds the sweep.
module aabb_pair_collision_sweep #(
    parameter int MAX_OBJECTS = aps_pkg::MaxObjectsDef
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  aps_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output aps_pkg::out_item_t m_data
);
    import aps_pkg::*;

    logic front_valid;
    logic front_ready;
    rec_t front_rec;
    logic back_valid;
    logic back_ready;
    rec_t back_rec;

    aps_front #(
        .MAX_OBJECTS(MAX_OBJECTS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (front_valid),
        .q_ready (front_ready),
        .q_data  (front_rec)
    );

    aps_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_rec),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_rec)
    );

    aps_back #(
        .MAX_OBJECTS(MAX_OBJECTS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (back_valid),
        .q_ready (back_ready),
        .q_data  (back_rec),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the box pair collision sweep
// Loads batches of object records, predicts every colliding ordered pair of
// each sweep and checks the results in order, with random idle cycles on the
// request side and random back-pressure on the result side.
// ----------------------------------------------------------------------------
module tb;
    import aps_pkg::*;

    localparam longint TimeoutNs = 64'd50_000_000;
    localparam int     PrintCap  = 40;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    aabb_pair_collision_sweep uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Shadow copy of the object store and the pairs still owed by the block.
    obj_t        obj_store [MaxObjectsDef];
    int unsigned obj_count = 0;
    out_item_t   owed_pairs [$];
    in_item_t    pending_objs [$];

    int unsigned pushed_cnt   = 0;
    int unsigned accepted_cnt = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned tx_pause     = 0;
    int unsigned rx_pause     = 0;
    bit          tx_idle_on   = 1'b1;
    bit          rx_idle_on   = 1'b1;

    function automatic int unsigned pick_pause();
        if ($urandom_range(0, 99) < 85) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Inclusive overlap on one axis; the sums need more than 32 bits.
    function automatic bit axis_touch(logic [31:0] a, logic [30:0] a_len,
                                      logic [31:0] b, logic [30:0] b_len);
        longint sa;
        longint sb;
        sa = longint'($signed(a));
        sb = longint'($signed(b));
        return (sb <= sa + longint'(a_len)) && (sa <= sb + longint'(b_len));
    endfunction

    task automatic collide_pairs(input in_item_t rec);
        out_item_t   found [64];
        int unsigned n_found;
        logic [7:0]  sm;
        n_found = 0;
        // A full store silently drops the record, but a last flag still sweeps.
        if (obj_count < MaxObjectsDef) begin
            obj_store[obj_count].corner_x = rec.pos_x + rec.offset_x;
            obj_store[obj_count].corner_y = rec.pos_y + rec.offset_y;
            obj_store[obj_count].corner_z = rec.pos_z + rec.offset_z;
            obj_store[obj_count].size_x   = rec.extent_x;
            obj_store[obj_count].size_y   = rec.extent_y;
            obj_store[obj_count].size_z   = rec.extent_z;
            obj_store[obj_count].send     = rec.send_mask;
            obj_store[obj_count].recv     = rec.recv_mask;
            obj_count++;
        end
        if (!rec.last_object) begin
            return;
        end
        for (int s = 0; s < obj_count; s++) begin
            sm = obj_store[s].send;
            if (sm == 8'h00) begin
                continue;
            end
            for (int t = 0; t < obj_count; t++) begin
                if ((sm & obj_store[t].recv) == 8'h00) begin
                    continue;
                end
                if (!axis_touch(obj_store[s].corner_x, obj_store[s].size_x,
                                obj_store[t].corner_x, obj_store[t].size_x) ||
                    !axis_touch(obj_store[s].corner_y, obj_store[s].size_y,
                                obj_store[t].corner_y, obj_store[t].size_y) ||
                    !axis_touch(obj_store[s].corner_z, obj_store[s].size_z,
                                obj_store[t].corner_z, obj_store[t].size_z)) begin
                    continue;
                end
                found[n_found].source_index = s[IndexW-1:0];
                found[n_found].target_index = t[IndexW-1:0];
                found[n_found].fire_hit     = |(sm & HitMask);
                found[n_found].fire_contact = |(sm & ContactMask);
                found[n_found].last_result  = 1'b0;
                n_found++;
            end
        end
        if (n_found == 0) begin
            found[0] = '0;
            n_found  = 1;
        end
        found[n_found - 1].last_result = 1'b1;
        for (int k = 0; k < n_found; k++) begin
            owed_pairs.push_back(found[k]);
        end
        obj_count = 0;
    endtask

    task automatic report_miss(input string what, input int got, input int want);
        mismatch_cnt++;
        if (mismatch_cnt <= PrintCap) begin
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        end
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (owed_pairs.size() == 0) begin
            report_miss("result with nothing pending, source_index",
                        got.source_index, 0);
            return;
        end
        want = owed_pairs.pop_front();
        if (got.source_index !== want.source_index)
            report_miss("source_index", got.source_index, want.source_index);
        if (got.target_index !== want.target_index)
            report_miss("target_index", got.target_index, want.target_index);
        if (got.fire_hit !== want.fire_hit)
            report_miss("fire_hit", got.fire_hit, want.fire_hit);
        if (got.fire_contact !== want.fire_contact)
            report_miss("fire_contact", got.fire_contact, want.fire_contact);
        if (got.last_result !== want.last_result)
            report_miss("last_result", got.last_result, want.last_result);
    endtask

    // Request driver: holds a request until taken, then maybe idles a while.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            tx_pause <= 0;
        end else begin
            if (s_valid && s_ready) begin
                collide_pairs(s_data);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (s_valid && !s_ready) begin
                // Request still waiting; keep it steady.
            end else if (tx_pause != 0) begin
                s_valid  <= 1'b0;
                tx_pause <= tx_pause - 1;
            end else if (pending_objs.size() != 0) begin
                s_data   <= pending_objs.pop_front();
                s_valid  <= 1'b1;
                tx_pause <= (tx_idle_on && $urandom_range(0, 99) < 40) ? pick_pause() : 0;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            rx_pause <= 0;
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_data);
            end
            if (rx_pause != 0) begin
                m_ready  <= 1'b0;
                rx_pause <= rx_pause - 1;
            end else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
                m_ready  <= 1'b0;
                rx_pause <= pick_pause() - 1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic in_item_t mk_obj(int px, int py, int pz, int ox, int oy, int oz,
                                        int unsigned ex, int unsigned ey, int unsigned ez,
                                        logic [7:0] sm, logic [7:0] rm, bit last);
        in_item_t it;
        it.pos_x       = px;
        it.pos_y       = py;
        it.pos_z       = pz;
        it.offset_x    = ox;
        it.offset_y    = oy;
        it.offset_z    = oz;
        it.extent_x    = ex[30:0];
        it.extent_y    = ey[30:0];
        it.extent_z    = ez[30:0];
        it.send_mask   = sm;
        it.recv_mask   = rm;
        it.last_object = last;
        return it;
    endfunction

    function automatic in_item_t random_obj(bit last);
        in_item_t    it;
        int unsigned mode;
        int unsigned r;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            // Clustered near the origin so that many pairs collide.
            it = mk_obj(int'($urandom_range(0, 1200)) - 600,
                        int'($urandom_range(0, 1200)) - 600,
                        int'($urandom_range(0, 1200)) - 600,
                        int'($urandom_range(0, 200)) - 100,
                        int'($urandom_range(0, 200)) - 100,
                        int'($urandom_range(0, 200)) - 100,
                        $urandom_range(0, 400), $urandom_range(0, 400),
                        $urandom_range(0, 400), 8'h00, 8'h00, last);
        end else if (mode < 80) begin
            // Positions just below the top so that the corner sum wraps.
            it = mk_obj(32'sh7fffffff - int'($urandom_range(0, 500)),
                        32'sh7fffffff - int'($urandom_range(0, 500)),
                        int'($urandom_range(0, 1000)) - 500,
                        $urandom_range(0, 1000), $urandom_range(0, 1000), 0,
                        ($urandom_range(0, 2) == 0) ? 32'h7fffffff - $urandom_range(0, 9)
                                                    : $urandom_range(0, 600),
                        $urandom_range(0, 600), $urandom_range(0, 600),
                        8'h00, 8'h00, last);
        end else begin
            it = mk_obj($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom, 8'h00, 8'h00, last);
        end
        r = $urandom_range(0, 99);
        it.send_mask = (r < 12) ? 8'h00 : 8'($urandom_range(1, 255));
        r = $urandom_range(0, 99);
        it.recv_mask = (r < 10) ? 8'h00 : (r < 35) ? 8'hff : 8'($urandom_range(1, 255));
        return it;
    endfunction

    task automatic send_obj(input in_item_t it);
        pending_objs.push_back(it);
        pushed_cnt++;
    endtask

    // Hold off until every request is taken and every owed pair has come back.
    task automatic drain();
        while (accepted_cnt != pushed_cnt) @(posedge aclk);
        while (owed_pairs.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int unsigned batch_size;
        int unsigned r;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Lone object colliding with itself, zero extents, both flags.
        send_obj(mk_obj(0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hc3, 8'h01, 1'b1));
        drain();
        // Lone object that sends nothing: only the empty result.
        send_obj(mk_obj(100, -100, 7, 0, 0, 0, 5, 5, 5, 8'h00, 8'hff, 1'b1));
        drain();
        // Boxes touching exactly at x = 10; the pair that counts fires nothing.
        send_obj(mk_obj(0, 0, 0, 0, 0, 0, 10, 10, 10, 8'h3c, 8'h00, 1'b0));
        send_obj(mk_obj(10, 0, 0, 0, 0, 0, 0, 10, 10, 8'h40, 8'h04, 1'b1));
        drain();
        // One unit apart along z: self-pairs only, contact flag only.
        send_obj(mk_obj(0, 0, 0, 0, 0, 0, 10, 10, 10, 8'h01, 8'h01, 1'b0));
        send_obj(mk_obj(0, 0, 5, 0, 0, 6, 10, 10, 10, 8'h80, 8'h80, 1'b1));
        drain();
        // Corner sums that wrap, full-size extents, hit flag only.
        send_obj(mk_obj(32'sh7fffffff, 32'sh80000000, 0, 1, 0, 0,
                        32'h7fffffff, 32'h7fffffff, 0, 8'h02, 8'hff, 1'b0));
        send_obj(mk_obj(32'sh80000000, 0, 32'sh7fffffff, -1, 0, 0,
                        32'h7fffffff, 0, 32'h7fffffff, 8'h02, 8'hff, 1'b0));
        send_obj(mk_obj(-1, -1, -1, 0, 0, 0, 0, 0, 0, 8'h02, 8'hff, 1'b1));
        drain();
        // Full store: every pair collides, then two records are dropped and
        // the dropped last one still starts the sweep.
        for (int i = 0; i < MaxObjectsDef; i++) begin
            send_obj(mk_obj(i, -i, 2 * i, 0, 0, 0, 20, 20, 20, 8'h83, 8'hff, 1'b0));
        end
        send_obj(mk_obj(5000, 5000, 5000, 0, 0, 0, 1, 1, 1, 8'hff, 8'hff, 1'b0));
        send_obj(mk_obj(-5000, 0, 0, 0, 0, 0, 1, 1, 1, 8'hff, 8'hff, 1'b1));
        drain();

        while (pushed_cnt < 275) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 10) begin
                batch_size = $urandom_range(9, 11);
            end else if (r < 20) begin
                batch_size = 1;
            end else begin
                batch_size = $urandom_range(2, MaxObjectsDef);
            end
            for (int i = 0; i < batch_size; i++) begin
                send_obj(random_obj(i == batch_size - 1));
            end
            if ($urandom_range(0, 5) == 0) begin
                drain();
            end
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatch_cnt == 0) begin
            $display("aabb_pair_collision_sweep: match");
        end else begin
            $display("aabb_pair_collision_sweep: mismatch");
        end
        $finish;
    end

    initial begin
        #(TimeoutNs);
        $display("aabb_pair_collision_sweep: mismatch");
        $finish;
    end

endmodule
